### sv/fvc_pkg.sv
// Shared types and constants for the valid-mode FIR correlation block.
// Used by fvc_cell and fir_valid_correlation. No dependencies.
package fvc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int OUT_W    = 38;
  localparam int TAP_W    = 7;
  localparam int CIDX_W   = 6;

  localparam logic CMD_COEFF  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } fvc_state_t;

  // Per-cycle controls broadcast to every cell of the chain
  typedef struct packed {
    logic hist_shift;  // push a new sample into the history chain
    logic rot_up;      // rotate aligned coefficients toward higher index
    logic rot_dn;      // rotate aligned coefficients toward lower index
    logic coef_wr;     // coefficient write, cell selected by target index
    logic run;         // accumulate one step toward cell 0
    logic clear;       // zero the partial sums
  } cell_ctrl_t;

endpackage

### sv/fvc_cell.sv
// One tap cell: history sample, aligned coefficient, product and partial sum.
// Depends on fvc_pkg; instantiated in a chain by fir_valid_correlation.
module fvc_cell #(
  parameter int IDX = 0,
  parameter int NW  = 7,
  parameter int AW  = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fvc_pkg::cell_ctrl_t              ctrl,
  input  logic [NW-1:0]                    active_n,
  input  logic [AW-1:0]                    coef_target,
  input  logic signed [fvc_pkg::COEF_W-1:0]   coef_wdata,
  input  logic signed [fvc_pkg::SAMPLE_W-1:0] hist_in,
  input  logic signed [fvc_pkg::COEF_W-1:0]   coef_up_in,
  input  logic signed [fvc_pkg::COEF_W-1:0]   coef_dn_in,
  input  logic signed [fvc_pkg::OUT_W-1:0]    acc_in,
  output logic signed [fvc_pkg::SAMPLE_W-1:0] hist_out,
  output logic signed [fvc_pkg::COEF_W-1:0]   coef_out,
  output logic signed [fvc_pkg::OUT_W-1:0]    acc_out
);
  import fvc_pkg::*;

  logic signed [SAMPLE_W-1:0] hist_r;
  logic signed [COEF_W-1:0]   coef_r;
  logic signed [COEF_W-1:0]   coef_nxt;
  logic signed [OUT_W-1:0]    acc_r;
  logic signed [OUT_W-1:0]    acc_nxt;
  logic signed [PROD_W-1:0]   prod;
  logic                       active;

  assign prod   = hist_r * coef_r;
  // taps at or beyond the count in use add nothing
  assign active = NW'(IDX) < active_n;

  always_comb begin
    coef_nxt = coef_r;
    if (ctrl.rot_up) begin
      coef_nxt = coef_up_in;
    end else if (ctrl.rot_dn) begin
      coef_nxt = coef_dn_in;
    end else if (ctrl.coef_wr && (coef_target == AW'(IDX))) begin
      coef_nxt = coef_wdata;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.run) begin
      if (active) begin
        acc_nxt = acc_in + {{(OUT_W-PROD_W){prod[PROD_W-1]}}, prod};
      end else begin
        acc_nxt = acc_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.hist_shift) begin
      hist_r <= hist_in;
    end
    acc_r <= acc_nxt;
  end

  assign hist_out = hist_r;
  assign coef_out = coef_r;
  assign acc_out  = acc_r;

endmodule

### sv/fir_valid_correlation.sv
// Valid-mode FIR correlator: sequencer, tap count register and a chain of fvc_cell.
// A sample that completes a window starts a run: the sum steps across the taps in use
// toward cell 0 (ST_RUN), then goes to the output register (ST_DONE) unless output stalls.
// Input stalls until then; coefficient writes and samples that give no result need no run.
// When idle, tap count changes rotate coefficients one position a cycle (up to MAX_TAPS-1).
// Reset is synchronous: coefficients clear to zero, tap count becomes one.
module fir_valid_correlation #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic signed [fvc_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [fvc_pkg::CIDX_W-1:0]          in_coeff_index,
  input  logic signed [fvc_pkg::COEF_W-1:0]   in_coeff_value,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fvc_pkg::OUT_W-1:0]    out_filtered_value,
  output logic                                out_frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fvc_pkg::TAP_W-1:0]           cfg_data
);
  import fvc_pkg::*;

  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int EW = (NW > TAP_W) ? NW : TAP_W;
  localparam int DW = EW + 1;
  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  logic [TAP_W-1:0]        tap_count_r;
  logic [NW-1:0]           aligned_r;
  logic [NW-1:0]           aligned_nxt;
  logic [NW-1:0]           fill_r;
  logic [NW-1:0]           fill_nxt;
  logic [NW-1:0]           fill_inc;
  logic [NW-1:0]           cnt_r;
  logic [NW-1:0]           cnt_nxt;
  fvc_state_t              state_r;
  fvc_state_t              state_nxt;
  logic                    last_r;
  logic                    last_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [OUT_W-1:0] out_value_r;
  logic                    out_last_r;
  logic                    out_load;

  logic [EW-1:0]           tc_ext;
  logic [EW-1:0]           eff_ext;
  logic [NW-1:0]           eff_n;
  logic                    realign;
  logic                    accept;
  logic                    is_sample;
  logic                    produce;
  logic [DW-1:0]           n1;
  logic [DW-1:0]           kx;
  logic [DW-1:0]           tgt;
  logic [AW-1:0]           coef_target;
  cell_ctrl_t              ctrl;

  logic signed [SAMPLE_W-1:0] hist_w [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_w [MAX_TAPS];
  logic signed [OUT_W-1:0]    acc_w  [MAX_TAPS];

  // taps in use: zero counts as one, clamp at MAX_TAPS
  always_comb begin
    tc_ext = EW'(tap_count_r);
    if (tc_ext == '0) begin
      eff_ext = EW'(1);
    end else if (tc_ext > EW'(MAX_TAPS)) begin
      eff_ext = EW'(MAX_TAPS);
    end else begin
      eff_ext = tc_ext;
    end
  end
  assign eff_n = NW'(eff_ext);

  assign cfg_ready = 1'b1;
  assign realign   = aligned_r != eff_n;
  assign in_stall  = (state_r != ST_IDLE) || realign;
  assign accept    = in_valid && !in_stall;
  assign is_sample = in_cmd == CMD_SAMPLE;
  assign fill_inc  = (fill_r < NW'(MAX_TAPS)) ? fill_r + NW'(1) : fill_r;
  assign produce   = fill_inc >= eff_n;

  // cell j holds c[(n-1-j) mod MAX_TAPS], so it pairs with history slot j
  assign n1  = DW'(eff_n) - DW'(1);
  assign kx  = DW'(in_coeff_index);
  assign tgt = (kx <= n1) ? (n1 - kx) : (n1 + DW'(MAX_TAPS) - kx);
  assign coef_target = AW'(tgt);

  always_comb begin
    ctrl.hist_shift = accept && is_sample;
    ctrl.coef_wr    = accept && !is_sample && (EW'(in_coeff_index) < EW'(MAX_TAPS));
    ctrl.rot_up     = (state_r == ST_IDLE) && realign && (eff_n > aligned_r);
    ctrl.rot_dn     = (state_r == ST_IDLE) && realign && (eff_n < aligned_r);
    ctrl.run        = state_r == ST_RUN;
    ctrl.clear      = state_r == ST_IDLE;
  end

  always_comb begin
    aligned_nxt = aligned_r;
    if (ctrl.rot_up) begin
      aligned_nxt = aligned_r + NW'(1);
    end else if (ctrl.rot_dn) begin
      aligned_nxt = aligned_r - NW'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    last_nxt      = last_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_sample) begin
          fill_nxt = in_frame_end ? '0 : fill_inc;
          last_nxt = in_frame_end;
          if (produce) begin
            state_nxt = ST_RUN;
            cnt_nxt   = '0;
          end
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == eff_n - NW'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_W'(1);
      aligned_r   <= NW'(1);
      fill_r      <= '0;
      cnt_r       <= '0;
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tap_count_r <= cfg_data;
      end
      aligned_r   <= aligned_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= acc_w[0];
      out_last_r  <= last_r;
    end
  end

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic signed [SAMPLE_W-1:0] hist_in;
    logic signed [OUT_W-1:0]    acc_in;

    if (j == 0) begin : g_head
      assign hist_in = in_sample_value;
    end else begin : g_body
      assign hist_in = hist_w[j-1];
    end

    // partial sums flow toward cell 0; the far end feeds zero
    if (j == MAX_TAPS - 1) begin : g_tail
      assign acc_in = '0;
    end else begin : g_mid
      assign acc_in = acc_w[j+1];
    end

    fvc_cell #(
      .IDX (j),
      .NW  (NW),
      .AW  (AW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .active_n    (eff_n),
      .coef_target (coef_target),
      .coef_wdata  (in_coeff_value),
      .hist_in     (hist_in),
      .coef_up_in  (coef_w[(j + MAX_TAPS - 1) % MAX_TAPS]),
      .coef_dn_in  (coef_w[(j + 1) % MAX_TAPS]),
      .acc_in      (acc_in),
      .hist_out    (hist_w[j]),
      .coef_out    (coef_w[j]),
      .acc_out     (acc_w[j])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;
  assign out_frame_last     = out_last_r;

  a_run_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (aligned_r == eff_n))
    else $error("accumulation started with misaligned coefficients");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r < eff_n))
    else $error("step counter beyond taps in use");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NW'(MAX_TAPS))
    else $error("fill count above MAX_TAPS");

  a_aligned_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    aligned_r != '0)
    else $error("alignment count at zero");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && !(out_valid_r && out_stall))
      |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished sum not moved to output register");

endmodule

### bench/fir_valid_correlation_test.sv
// Self-checking bench for fir_valid_correlation: directed corner items, then random
// frames over several tap settings, checked by a cycle-free correlation predictor.
// Depends on fvc_pkg and the fir_valid_correlation RTL.
module fir_valid_correlation_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fvc_pkg::*;

  localparam int TAPS_MAX   = 64;
  localparam int RAND_ITEMS = 750;

  class fir_scoreboard;
    typedef struct {
      logic signed [OUT_W-1:0] sum;
      logic                    frame_last;
    } fir_result_t;

    logic signed [COEF_W-1:0]   coef_mem [TAPS_MAX];
    logic signed [SAMPLE_W-1:0] history  [TAPS_MAX];  // newest first
    int                         fill;
    logic [TAP_W-1:0]           tap_reg;
    fir_result_t                pending_sums [$];
    int                         errors;

    function new();
      for (int i = 0; i < TAPS_MAX; i++) begin
        coef_mem[i] = '0;
        history[i]  = '0;
      end
      fill    = 0;
      tap_reg = 7'd1;
      errors  = 0;
    endfunction

    function void set_taps(logic [TAP_W-1:0] v);
      tap_reg = v;
    endfunction

    function int taps_in_use();
      if (tap_reg == 0) return 1;
      if (tap_reg > TAPS_MAX) return TAPS_MAX;
      return int'(tap_reg);
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction

    // Accepted input transfer: update state, queue the expected sum if the window is full.
    function void apply_transfer(logic cmd, logic signed [SAMPLE_W-1:0] smp,
                                 logic [CIDX_W-1:0] idx, logic signed [COEF_W-1:0] cv,
                                 logic fe);
      longint      acc;
      int          n;
      int          k;
      fir_result_t r;
      if (cmd == CMD_COEFF) begin
        coef_mem[idx] = cv;
        return;
      end
      for (k = TAPS_MAX - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = smp;
      if (fill < TAPS_MAX) fill++;
      n = taps_in_use();
      if (fill < n) begin
        if (fe) fill = 0;
        return;
      end
      acc = 0;
      for (k = 0; k < n; k++)
        acc += longint'(history[n-1-k]) * longint'(coef_mem[k]);
      r.sum        = acc[OUT_W-1:0];
      r.frame_last = fe;
      pending_sums.push_back(r);
      if (fe) fill = 0;
    endfunction

    function void check_result(logic signed [OUT_W-1:0] sum, logic frame_last);
      fir_result_t r;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result filtered_value=%0d frame_last=%0b",
                 $time, sum, frame_last);
        errors++;
        return;
      end
      r = pending_sums.pop_front();
      if (sum !== r.sum) begin
        $display("%0t: filtered_value expected %0d actual %0d", $time, r.sum, sum);
        errors++;
      end
      if (frame_last !== r.frame_last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, r.frame_last, frame_last);
        errors++;
      end
    endfunction
  endclass

  typedef struct {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] smp;
    logic [CIDX_W-1:0]          idx;
    logic signed [COEF_W-1:0]   cv;
    logic                       fe;
  } fir_item_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_cmd;
  logic signed [SAMPLE_W-1:0] in_sample_value;
  logic [CIDX_W-1:0]          in_coeff_index;
  logic signed [COEF_W-1:0]   in_coeff_value;
  logic                       in_frame_end;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [OUT_W-1:0]    out_filtered_value;
  logic                       out_frame_last;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [TAP_W-1:0]           cfg_data;

  fir_scoreboard sb = new();

  int burst_left;
  int items_sent;
  int results_seen;
  int stall_mode;
  int mode_left;
  int hold_left;
  bit hold_done;

  fir_valid_correlation #(.MAX_TAPS(TAPS_MAX)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_sample_value    (in_sample_value),
    .in_coeff_index     (in_coeff_index),
    .in_coeff_value     (in_coeff_value),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_value (out_filtered_value),
    .out_frame_last     (out_frame_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sender works in bursts; a burst boundary inserts a random gap.
  task automatic send_item(input fir_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_cmd          <= it.cmd;
    in_sample_value <= it.smp;
    in_coeff_index  <= it.idx;
    in_coeff_value  <= it.cv;
    in_frame_end    <= it.fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_transfer(it.cmd, it.smp, it.idx, it.cv, it.fe);
    items_sent++;
  endtask

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input logic fe);
    fir_item_t it;
    it.cmd = CMD_SAMPLE;
    it.smp = v;
    it.idx = CIDX_W'($urandom);  // ignored on samples
    it.cv  = 16'($urandom);
    it.fe  = fe;
    send_item(it);
  endtask

  task automatic send_coeff(input logic [CIDX_W-1:0] idx, input logic signed [COEF_W-1:0] v,
                            input logic fe);
    fir_item_t it;
    it.cmd = CMD_COEFF;
    it.smp = 16'($urandom);
    it.idx = idx;
    it.cv  = v;
    it.fe  = fe;
    send_item(it);
  endtask

  // Tap count writes only once the block has drained; a coefficient rotation may follow.
  task automatic write_taps(input logic [TAP_W-1:0] v);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * TAPS_MAX + 8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_taps(v);
  endtask

  // Receiver: checks each transfer, stalls in changing modes, one long hold-off.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_filtered_value, out_frame_last);
      results_seen++;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin
    #12_000_000;
    $display("fir_valid_correlation verification failed");
    $finish;
  end

  initial begin
    int taps_plan [$];
    int phase;
    int taps;
    int eff;
    int budget;
    int flen;
    int j;
    int stop_at;

    taps_plan    = '{64, 2, 127, 0, 1, 5, 64, 3, 17};
    burst_left   = 0;
    items_sent   = 0;
    results_seen = 0;
    stall_mode   = 0;
    mode_left    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_cmd          <= CMD_SAMPLE;
    in_sample_value <= '0;
    in_coeff_index  <= '0;
    in_coeff_value  <= '0;
    in_frame_end    <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_data        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one tap after reset, extremes of samples and coefficients
    send_coeff(6'd0, 16'sh7fff, 1'b1);     // frame_end on a coefficient write is ignored
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_coeff(6'd63, 16'sh8000, 1'b0);
    send_coeff(6'd0, 16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b1);
    write_taps(7'd0);                      // zero taps acts as one
    send_sample(16'sd12345, 1'b1);
    write_taps(7'd3);
    send_coeff(6'd1, -16'sd1, 1'b0);
    send_coeff(6'd2, 16'sh7fff, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sh8000, 1'b1);          // frame ends before it fills
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_coeff(6'd1, 16'sh7fff, 1'b0);     // coefficient changed inside a frame
    send_sample(16'sd6, 1'b0);
    send_sample(16'sd7, 1'b1);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd10, 1'b0);
    write_taps(7'd2);                      // tap count shrinks mid-frame
    send_sample(-16'sd7, 1'b1);

    // Random frames over a range of tap settings
    stop_at = items_sent + RAND_ITEMS;
    phase   = 0;
    while (items_sent < stop_at) begin
      if (phase < taps_plan.size()) begin
        taps = taps_plan[phase];
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: taps = $urandom_range(1, 8);
          5, 6, 7:       taps = $urandom_range(9, 32);
          default:       taps = $urandom_range(0, 127);
        endcase
      end
      write_taps(taps[TAP_W-1:0]);
      eff = (taps == 0) ? 1 : (taps > TAPS_MAX) ? TAPS_MAX : taps;

      if (phase == 0) begin
        for (j = 0; j < TAPS_MAX; j++) send_coeff(j[CIDX_W-1:0], rand_word(), 1'($urandom));
      end else begin
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 3) == 0)
            send_coeff(CIDX_W'($urandom), rand_word(), 1'($urandom));
          else
            send_coeff(CIDX_W'($urandom_range(0, eff - 1)), rand_word(), 1'($urandom));
        end
      end

      budget = items_sent + ((eff <= 8) ? $urandom_range(30, 60)
                                        : 2 * eff + $urandom_range(10, 40));
      while (items_sent < budget && items_sent < stop_at) begin
        // mostly frames long enough to fill, some that end early
        if ($urandom_range(0, 4) != 0) flen = eff + $urandom_range(0, eff + 3);
        else                           flen = $urandom_range(1, eff);
        for (j = 0; j < flen && items_sent < budget; j++) begin
          if ($urandom_range(0, 19) == 0)
            send_coeff(CIDX_W'($urandom), rand_word(), 1'($urandom));
          send_sample(rand_word(), j == flen - 1);
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * TAPS_MAX + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("fir_valid_correlation verification clean");
    else
      $display("fir_valid_correlation verification failed");
    $finish;
  end

endmodule

### sim.f
sv/fvc_pkg.sv
sv/fvc_cell.sv
sv/fir_valid_correlation.sv
bench/fir_valid_correlation_test.sv
